// ===== hdl/vm_instruction_decoder_defines.svh =====
// Assertion macros for the instruction decoder.
// Used by the top level only; depends on nothing else.
`ifndef VM_INSTRUCTION_DECODER_DEFINES_SVH
`define VM_INSTRUCTION_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMID_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("vm_instruction_decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VMID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("vm_instruction_decoder: next-cycle check failed");

`endif

// ===== hdl/vmid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and opcode table functions for the instruction decoder.
// No dependencies; vmid_core and the top level import this package.
package vmid_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_CODING,
      PHASE_ARGS
   } phase_type;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_REG  = 2'd1;
   localparam logic [1:0] MODE_DIR  = 2'd2;
   localparam logic [1:0] MODE_IND  = 2'd3;

   localparam logic [7:0] OP_FIRST      = 8'd1;
   localparam logic [7:0] OP_LIVE       = 8'd1;
   localparam logic [7:0] OP_ZJMP       = 8'd9;
   localparam logic [7:0] OP_LDI        = 8'd10;
   localparam logic [7:0] OP_STI        = 8'd11;
   localparam logic [7:0] OP_FORK       = 8'd12;
   localparam logic [7:0] OP_LLDI       = 8'd14;
   localparam logic [7:0] OP_LONG_SPAWN = 8'd15;
   localparam logic [7:0] OP_LAST       = 8'd16;

   localparam logic [5:0]  NO_CODING_MODES = {MODE_DIR, MODE_NONE, MODE_NONE};
   localparam logic [31:0] HIGH_FILL       = 32'hffff0000;

   typedef struct packed {
      logic [7:0]         opcode;
      logic               opcode_known;
      logic [1:0]         mode_first;
      logic [1:0]         mode_second;
      logic [1:0]         mode_third;
      logic signed [31:0] arg_first;
      logic signed [31:0] arg_second;
      logic signed [31:0] arg_third;
      logic [3:0]         length;
      logic [9:0]         cycle_cost;
   } rsp_type;

   function automatic logic lacks_coding_byte(input logic [7:0] op);
      return (op == OP_LIVE) || (op == OP_ZJMP) || (op == OP_FORK) ||
             (op == OP_LONG_SPAWN);
   endfunction

   function automatic logic short_direct(input logic [7:0] op);
      return (op == OP_ZJMP) || (op == OP_LDI) || (op == OP_STI) || (op == OP_FORK) ||
             (op == OP_LLDI) || (op == OP_LONG_SPAWN);
   endfunction

   function automatic logic [1:0] mode_of(input logic [5:0] modes, input logic [1:0] slot);
      logic [1:0] m;
      unique case (slot)
         2'd0: m = modes[5:4];
         2'd1: m = modes[3:2];
         2'd2: m = modes[1:0];
         default: m = MODE_NONE;
      endcase
      return m;
   endfunction

   function automatic logic [2:0] arg_size(input logic [1:0] mode, input logic [7:0] op);
      logic [2:0] n;
      unique case (mode)
         MODE_REG: n = 3'd1;
         MODE_DIR: n = short_direct(op) ? 3'd2 : 3'd4;
         MODE_IND: n = 3'd2;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [9:0] cost_of(input logic [7:0] op);
      logic [9:0] c;
      unique case (op)
         8'd1:    c = 10'd10;
         8'd2:    c = 10'd5;
         8'd3:    c = 10'd5;
         8'd4:    c = 10'd10;
         8'd5:    c = 10'd10;
         8'd6:    c = 10'd6;
         8'd7:    c = 10'd6;
         8'd8:    c = 10'd6;
         8'd9:    c = 10'd20;
         8'd10:   c = 10'd25;
         8'd11:   c = 10'd25;
         8'd12:   c = 10'd800;
         8'd13:   c = 10'd10;
         8'd14:   c = 10'd50;
         8'd15:   c = 10'd1000;
         8'd16:   c = 10'd2;
         default: c = 10'd0;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/vmid_req_if.sv =====
`timescale 1ns / 1ps
// Code byte channel of the instruction decoder: valid/ready and one byte per word.
// No dependencies.
interface vmid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       start_req;

   modport source (output valid, output code_byte, output start_req, input ready);
   modport sink   (input valid, input code_byte, input start_req, output ready);
endinterface

// ===== hdl/vmid_rsp_if.sv =====
`timescale 1ns / 1ps
// Decoded instruction channel of the instruction decoder: valid/ready and the result fields.
// No dependencies.
interface vmid_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         opcode;
   logic               opcode_known;
   logic [1:0]         mode_first;
   logic [1:0]         mode_second;
   logic [1:0]         mode_third;
   logic signed [31:0] arg_first;
   logic signed [31:0] arg_second;
   logic signed [31:0] arg_third;
   logic [3:0]         length;
   logic [9:0]         cycle_cost;

   modport source (output valid, output opcode, output opcode_known, output mode_first,
                   output mode_second, output mode_third, output arg_first,
                   output arg_second, output arg_third, output length,
                   output cycle_cost, input ready);
   modport sink   (input valid, input opcode, input opcode_known, input mode_first,
                   input mode_second, input mode_third, input arg_first,
                   input arg_second, input arg_third, input length,
                   input cycle_cost, output ready);
endinterface

// ===== hdl/vmid_core.sv =====
`timescale 1ns / 1ps
// Decode state registers and combinational byte step logic of the instruction decoder.
// Depends on vmid_pkg.
module vmid_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       code_byte,
   input  logic             start_req,
   output logic             emit,
   output vmid_pkg::rsp_type result
);
   import vmid_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [5:0]  modes_ff, modes_in;
   logic [1:0]  slot_ff, slot_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] store_ff [3];
   logic [31:0] store_in [3];
   logic [3:0]  count_ff, count_in;

   logic        do_begin;
   logic [1:0]  from_slot;
   logic        found;
   logic [1:0]  found_slot;
   logic [2:0]  size;
   logic [2:0]  left_dec;
   logic [31:0] acc_shift;
   logic [31:0] value;
   logic        known;

   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      modes_in    = modes_ff;
      slot_in     = slot_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      store_in[0] = store_ff[0];
      store_in[1] = store_ff[1];
      store_in[2] = store_ff[2];
      count_in    = count_ff;
      do_begin    = 1'b0;
      from_slot   = 2'd0;
      emit        = 1'b0;
      found       = 1'b0;
      found_slot  = 2'd0;
      size        = arg_size(mode_of(modes_ff, slot_ff), opcode_ff);
      left_dec    = (left_ff != 3'd0) ? left_ff - 3'd1 : 3'd0;
      acc_shift   = {acc_ff[23:0], code_byte};
      value       = acc_shift;
      if (size == 3'd2) begin
         value = acc_shift[15] ? ({16'h0000, acc_shift[15:0]} | HIGH_FILL)
                               : {16'h0000, acc_shift[15:0]};
      end

      if (step) begin
         if (start_req) begin
            opcode_in   = code_byte;
            store_in[0] = '0;
            store_in[1] = '0;
            store_in[2] = '0;
            acc_in      = '0;
            slot_in     = 2'd0;
            left_in     = 3'd0;
            count_in    = 4'd1;
            if (lacks_coding_byte(code_byte)) begin
               modes_in = NO_CODING_MODES;
               do_begin = 1'b1;
            end else begin
               modes_in = '0;
               phase_in = PHASE_CODING;
            end
         end else begin
            unique case (phase_ff)
               PHASE_CODING: begin
                  modes_in = code_byte[7:2];
                  count_in = count_ff + 4'd1;
                  do_begin = 1'b1;
               end
               PHASE_ARGS: begin
                  acc_in   = acc_shift;
                  count_in = count_ff + 4'd1;
                  left_in  = left_dec;
                  if (left_dec == 3'd0) begin
                     store_in[slot_ff] = value;
                     do_begin  = 1'b1;
                     from_slot = slot_ff + 2'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (do_begin) begin
         for (int s = 0; s < 3; s++) begin
            if (!found && (2'(s) >= from_slot) && (mode_of(modes_in, 2'(s)) != MODE_NONE)) begin
               found      = 1'b1;
               found_slot = 2'(s);
            end
         end
         if (found) begin
            slot_in  = found_slot;
            left_in  = arg_size(mode_of(modes_in, found_slot), opcode_in);
            acc_in   = '0;
            phase_in = PHASE_ARGS;
         end else begin
            emit     = 1'b1;
            phase_in = PHASE_IDLE;
         end
      end

      known               = (opcode_in >= OP_FIRST) && (opcode_in <= OP_LAST);
      result.opcode       = opcode_in;
      result.opcode_known = known;
      result.mode_first   = mode_of(modes_in, 2'd0);
      result.mode_second  = mode_of(modes_in, 2'd1);
      result.mode_third   = mode_of(modes_in, 2'd2);
      result.arg_first    = store_in[0];
      result.arg_second   = store_in[1];
      result.arg_third    = store_in[2];
      result.length       = count_in;
      result.cycle_cost   = known ? cost_of(opcode_in) : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         opcode_ff   <= '0;
         modes_ff    <= '0;
         slot_ff     <= '0;
         left_ff     <= '0;
         acc_ff      <= '0;
         store_ff[0] <= '0;
         store_ff[1] <= '0;
         store_ff[2] <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         modes_ff    <= modes_in;
         slot_ff     <= slot_in;
         left_ff     <= left_in;
         acc_ff      <= acc_in;
         store_ff[0] <= store_in[0];
         store_ff[1] <= store_in[1];
         store_ff[2] <= store_in[2];
         count_ff    <= count_in;
      end
   end

endmodule

// ===== hdl/vm_instruction_decoder.sv =====
`timescale 1ns / 1ps
// Instruction decoder top level: input register, decode step and result register.
// Depends on vmid_pkg, vmid_req_if, vmid_rsp_if, vmid_core and the defines header.
//
// The decoder takes one code byte per word and gives one decoded-instruction word after the
// last byte of each instruction. A byte accepted into the input register passes through the
// decode step once the result register is free, and the word it completes is loaded into the
// result register, which drives the result channel. The single decode step between the input
// and result registers lets bytes follow back to back while the output is taken. While a word
// waits in the result register and is not taken, the input register takes one more byte and
// then the input stalls until the word leaves.
`include "vm_instruction_decoder_defines.svh"

module vm_instruction_decoder (
   input  logic       clock,
   input  logic       reset,
   vmid_req_if.sink   req_chan,
   vmid_rsp_if.source rsp_chan
);
   import vmid_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   logic       out_free;
   logic       advance;
   logic       accept;
   logic       core_emit;
   rsp_type    core_result;
   logic       cost_consistent;
   logic       absent_first_clear;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   vmid_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .code_byte (in_byte_ff),
      .start_req (in_start_ff),
      .emit      (core_emit),
      .result    (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && core_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_chan.code_byte;
         in_start_ff <= req_chan.start_req;
      end
      if (advance && core_emit) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.opcode       = rsp_data_ff.opcode;
   assign rsp_chan.opcode_known = rsp_data_ff.opcode_known;
   assign rsp_chan.mode_first   = rsp_data_ff.mode_first;
   assign rsp_chan.mode_second  = rsp_data_ff.mode_second;
   assign rsp_chan.mode_third   = rsp_data_ff.mode_third;
   assign rsp_chan.arg_first    = rsp_data_ff.arg_first;
   assign rsp_chan.arg_second   = rsp_data_ff.arg_second;
   assign rsp_chan.arg_third    = rsp_data_ff.arg_third;
   assign rsp_chan.length       = rsp_data_ff.length;
   assign rsp_chan.cycle_cost   = rsp_data_ff.cycle_cost;

   assign cost_consistent    = rsp_data_ff.opcode_known == (rsp_data_ff.cycle_cost != 10'd0);
   assign absent_first_clear = (rsp_data_ff.mode_first != MODE_NONE) ||
                               (rsp_data_ff.arg_first == 32'sd0);

   `VMID_ASSERT_NEXT(a_emit_loads, clock, reset, advance && core_emit, rsp_valid_ff)
   `VMID_ASSERT_IMPLIES(a_cost_known, clock, reset, rsp_valid_ff, cost_consistent)
   `VMID_ASSERT_IMPLIES(a_absent_arg, clock, reset, rsp_valid_ff, absent_first_clear)
   `VMID_ASSERT_IMPLIES(a_length_set, clock, reset, rsp_valid_ff, rsp_data_ff.length != 4'd0)

endmodule

// ===== tb/sv/vm_instruction_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vm_instruction_decoder: feeds code bytes, predicts each decoded
// instruction in step with the accepted bytes and checks every decoded word that comes out.
// Depends on vmid_pkg, vmid_req_if, vmid_rsp_if and the decoder RTL.
module vm_instruction_decoder_test;
   import vmid_pkg::*;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 220;

   localparam logic [7:0] OP_BAD_LOW  = 8'd0;
   localparam logic [7:0] OP_LD       = 8'd2;
   localparam logic [7:0] OP_ADD      = 8'd4;
   localparam logic [7:0] OP_SUB      = 8'd5;
   localparam logic [7:0] OP_AND      = 8'd6;
   localparam logic [7:0] OP_PAST_END = 8'd17;
   localparam logic [7:0] OP_BAD_HIGH = 8'd255;

   localparam logic [9:0] COST_BY_OP [16] = '{10'd10, 10'd5, 10'd5, 10'd10,
                                              10'd10, 10'd6, 10'd6, 10'd6,
                                              10'd20, 10'd25, 10'd25, 10'd800,
                                              10'd10, 10'd50, 10'd1000, 10'd2};

   logic clock = 1'b0;
   logic reset = 1'b1;

   vmid_req_if req_chan ();
   vmid_rsp_if rsp_chan ();

   vm_instruction_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   phase_type          dec_phase = PHASE_IDLE;
   logic [7:0]         dec_opcode = '0;
   logic [5:0]         dec_modes = '0;
   int                 dec_slot = 0;
   int                 dec_left = 0;
   logic [31:0]        dec_acc = '0;
   logic signed [31:0] dec_args [3] = '{default: '0};
   logic [3:0]         dec_count = '0;

   rsp_type pending_decodes [$];
   int      failures = 0;
   int      cycle_count = 0;
   int      stream_bytes = 0;
   int      rsp_hold_cycles = 0;
   bit      gaps_on = 1'b1;
   bit      stalls_on = 1'b1;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("vm_instruction_decoder verification failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_opcode();
      if ($urandom_range(0, 9) != 0) return 8'($urandom_range(OP_FIRST, OP_LAST));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [1:0] slot_mode(input int slot);
      case (slot)
         0: return dec_modes[5:4];
         1: return dec_modes[3:2];
         default: return dec_modes[1:0];
      endcase
   endfunction

   function automatic int mode_bytes(input logic [1:0] m);
      case (m)
         MODE_REG: return 1;
         MODE_DIR:
            return (dec_opcode inside {OP_ZJMP, OP_LDI, OP_STI, OP_FORK, OP_LLDI,
                                       OP_LONG_SPAWN}) ? 2 : 4;
         MODE_IND: return 2;
         default: return 0;
      endcase
   endfunction

   // Moves to the next argument that has a mode, or completes the instruction.
   task automatic next_arg(input int from);
      rsp_type d;
      bit      found;
      bit      known;
      found = 1'b0;
      for (int s = from; s < 3 && !found; s++) begin
         if (slot_mode(s) != MODE_NONE) begin
            dec_slot  = s;
            dec_left  = mode_bytes(slot_mode(s));
            dec_acc   = '0;
            dec_phase = PHASE_ARGS;
            found     = 1'b1;
         end
      end
      if (!found) begin
         known          = (dec_opcode >= OP_FIRST) && (dec_opcode <= OP_LAST);
         d.opcode       = dec_opcode;
         d.opcode_known = known;
         d.mode_first   = slot_mode(0);
         d.mode_second  = slot_mode(1);
         d.mode_third   = slot_mode(2);
         d.arg_first    = dec_args[0];
         d.arg_second   = dec_args[1];
         d.arg_third    = dec_args[2];
         d.length       = dec_count;
         d.cycle_cost   = known ? COST_BY_OP[4'(dec_opcode - OP_FIRST)] : 10'd0;
         pending_decodes.push_back(d);
         dec_phase = PHASE_IDLE;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic s);
      if (s) begin
         dec_opcode = b;
         dec_args   = '{default: '0};
         dec_acc    = '0;
         dec_slot   = 0;
         dec_left   = 0;
         dec_count  = 4'd1;
         if (b inside {OP_LIVE, OP_ZJMP, OP_FORK, OP_LONG_SPAWN}) begin
            dec_modes = NO_CODING_MODES;
            next_arg(0);
         end else begin
            dec_modes = '0;
            dec_phase = PHASE_CODING;
         end
      end else if (dec_phase == PHASE_CODING) begin
         dec_modes = b[7:2];
         dec_count = dec_count + 4'd1;
         next_arg(0);
      end else if (dec_phase == PHASE_ARGS) begin
         dec_acc   = {dec_acc[23:0], b};
         dec_count = dec_count + 4'd1;
         if (dec_left > 0) dec_left--;
         if (dec_left == 0) begin
            if (mode_bytes(slot_mode(dec_slot)) == 2)
               dec_args[dec_slot] = {{16{dec_acc[15]}}, dec_acc[15:0]};
            else
               dec_args[dec_slot] = dec_acc;
            next_arg(dec_slot + 1);
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic s);
      int gap;
      if (s || dec_phase != PHASE_IDLE) stream_bytes++;
      req_chan.valid     <= 1'b1;
      req_chan.code_byte <= b;
      req_chan.start_req <= s;
      do @(posedge clock); while (!req_chan.ready);
      decode_byte(b, s);
      gap = gaps_on ? gap_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A negative fill gives random argument bytes.
   task automatic send_instr(input logic [7:0] op, input logic [7:0] coding, input int fill);
      send_byte(op, 1'b1);
      if (dec_phase == PHASE_CODING) send_byte(coding, 1'b0);
      while (dec_phase == PHASE_ARGS) send_byte(fill < 0 ? pick_byte() : 8'(fill), 1'b0);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_decodes.size() == 0) begin
            $display("%0t: decoded word with none expected, expected nothing, actual opcode %0h",
                     $time, rsp_chan.opcode);
            failures++;
         end else begin
            want = pending_decodes.pop_front();
            check_field("opcode", want.opcode, rsp_chan.opcode);
            check_field("opcode_known", want.opcode_known, rsp_chan.opcode_known);
            check_field("mode_first", want.mode_first, rsp_chan.mode_first);
            check_field("mode_second", want.mode_second, rsp_chan.mode_second);
            check_field("mode_third", want.mode_third, rsp_chan.mode_third);
            check_field("arg_first", want.arg_first, rsp_chan.arg_first);
            check_field("arg_second", want.arg_second, rsp_chan.arg_second);
            check_field("arg_third", want.arg_third, rsp_chan.arg_third);
            check_field("length", want.length, rsp_chan.length);
            check_field("cycle_cost", want.cycle_cost, rsp_chan.cycle_cost);
         end
      end
   end

   // The receiver stalls at random, and for a long stretch whenever a test asks for one.
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         n = (rsp_hold_cycles > 0) ? rsp_hold_cycles : (stalls_on ? gap_len() : 0);
         rsp_hold_cycles = 0;
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic test_each_opcode();
      int op;
      for (op = OP_FIRST; op <= OP_LAST; op++)
         send_instr(8'(op), 8'(op * 37), (op % 2 != 0) ? 8'hff : 8'h80);
      drain();
   endtask

   task automatic test_special_cases();
      // Bytes without a start while idle are dropped.
      send_byte(8'h55, 1'b0);
      send_byte(8'haa, 1'b0);
      // An empty coding byte finishes the instruction; its two low bits do not matter.
      send_instr(OP_ADD, {MODE_NONE, MODE_NONE, MODE_NONE, 2'b11}, 0);
      // Restarts in the middle of the arguments and on the coding byte.
      send_byte(OP_LD, 1'b1);
      send_byte({MODE_IND, MODE_IND, MODE_IND, 2'b00}, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_instr(OP_LAST, {MODE_REG, MODE_REG, MODE_REG, 2'b00}, 8'h7f);
      send_byte(OP_SUB, 1'b1);
      send_instr(OP_AND, {MODE_IND, MODE_DIR, MODE_NONE, 2'b00}, 0);
      send_byte(OP_LIVE, 1'b1);
      send_byte(8'h01, 1'b0);
      send_instr(OP_ZJMP, 8'h00, 8'hff);
      // Unknown opcodes take four-byte direct arguments.
      send_instr(OP_BAD_LOW, {MODE_DIR, MODE_DIR, MODE_DIR, 2'b00}, 8'h7f);
      send_instr(OP_PAST_END, {MODE_IND, MODE_IND, MODE_IND, 2'b00}, 8'hff);
      send_instr(OP_BAD_HIGH, {MODE_IND, MODE_DIR, MODE_REG, 2'b00}, -1);
      // Negative short values are sign-extended.
      send_instr(OP_LDI, {MODE_IND, MODE_DIR, MODE_IND, 2'b01}, 8'h80);
      drain();
   endtask

   task automatic test_result_backpressure();
      gaps_on         = 1'b0;
      stalls_on       = 1'b0;
      rsp_hold_cycles = 300;
      repeat (40) send_instr(OP_LAST, {MODE_REG, MODE_NONE, MODE_NONE, 2'b00}, -1);
      drain();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_random_stream();
      int first;
      int r;
      first = stream_bytes;
      while (stream_bytes - first < RANDOM_BYTES) begin
         if ($urandom_range(0, 49) == 0) begin
            gaps_on   = $urandom_range(0, 1);
            stalls_on = $urandom_range(0, 1);
         end
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_instr(pick_opcode(), 8'($urandom), -1);
         end else if (r < 85) begin
            send_byte(pick_opcode(), 1'b1);
            repeat ($urandom_range(0, 3)) send_byte(pick_byte(), 1'b0);
         end else if (r < 93) begin
            send_byte(pick_byte(), 1'($urandom_range(0, 1)));
         end else begin
            send_instr(pick_opcode(), {6'b000000, 2'($urandom_range(0, 3))}, -1);
         end
      end
      drain();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.code_byte = 8'h00;
      req_chan.start_req = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_each_opcode();
      test_special_cases();
      test_result_backpressure();
      test_random_stream();
      if (failures == 0)
         $display("vm_instruction_decoder verification clean");
      else
         $display("vm_instruction_decoder verification failed");
      $finish;
   end

endmodule
